@@ sv/rcf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and factor functions for the rgb565 color filter
// no dependencies

package rcf_pkg;

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int NSTAGE   = 6;

    typedef enum logic [2:0] {
        REG_BIAS       = 3'd0,
        REG_CONTRAST   = 3'd1,
        REG_SATURATION = 3'd2,
        REG_RED_GAIN   = 3'd3,
        REG_GREEN_GAIN = 3'd4,
        REG_BLUE_GAIN  = 3'd5
    } reg_idx_t;

    localparam logic [7:0] BIAS_RESET = 8'd0;
    localparam logic [7:0] PCT_RESET  = 8'd100;

    // ceil(2^23 / 100), exact for pct*128/100 and pct*256/100 over 8-bit pct
    localparam logic [16:0] RECIP_100 = 17'd83887;

    localparam logic [6:0] LUMA_R = 7'd38;
    localparam logic [6:0] LUMA_G = 7'd75;
    localparam logic [6:0] LUMA_B = 7'd15;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } pipe_ctl_t;

    function automatic logic [8:0] pct_to_k128(input logic [7:0] pct);
        logic [24:0] prod;
        prod = 25'(pct) * 25'(RECIP_100);
        return prod[24:16];
    endfunction

    function automatic logic [9:0] pct_to_k256(input logic [7:0] pct);
        logic [24:0] prod;
        prod = 25'(pct) * 25'(RECIP_100);
        return prod[24:15];
    endfunction

endpackage

@@ sv/rgb565_color_filter_exact_core.sv @@
`timescale 1ns / 1ps
// rgb565 brightness, contrast, saturation and gain filter, top level
// depends on rcf_pkg and rcf_chan
//
// usage:
//   input channel in_valid/in_ready carries pixel_in (rgb565) and last_in;
//   output channel out_valid/out_ready carries pixel_out and last_out.
//   one item in gives exactly one item out, in order.
//   apb port: six 8-bit registers at byte addresses 0,4,..,20 (bias, contrast,
//   saturation, red, green and blue gain); write only while no item is in flight.
//   pipeline: six register stages (contrast multiply, bias/clamp, saturation
//   multiply, clamp, gain multiply, output register); the first stage loads at acceptance.
//   throughput: one item per cycle while out_ready stays high.
//   stall: a low out_ready holds the output item; stages behind it keep
//   filling empty slots and in_ready drops only when every stage is full.
//   reset: pipeline empties, bias reads 0 and all percentages read 100.

module rgb565_color_filter_exact_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [15:0]               pixel_in,
    input  logic                      last_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               pixel_out,
    output logic                      last_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rcf_pkg::ADDR_W-1:0] paddr,
    input  logic [rcf_pkg::DATA_W-1:0] pwdata,
    output logic [rcf_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import rcf_pkg::*;

    logic [7:0]        bias_reg;
    logic [7:0]        contrast_reg;
    logic [7:0]        sat_reg;
    logic [7:0]        rgain_reg;
    logic [7:0]        ggain_reg;
    logic [7:0]        bgain_reg;
    logic [8:0]        kc_reg;
    logic [8:0]        ks_reg;
    logic [9:0]        kgr_reg;
    logic [9:0]        kgg_reg;
    logic [9:0]        kgb_reg;
    logic              wr_en;
    logic [2:0]        wr_idx;
    logic [7:0]        rd_byte;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] last_reg;
    pipe_ctl_t         ctl;

    logic [7:0]        r8;
    logic [7:0]        g8;
    logic [7:0]        b8;
    logic [14:0]       luma_sum;
    logic [7:0]        gray_next;
    logic [7:0]        gray_s1_reg;
    logic [7:0]        gray_s2_reg;
    logic [7:0]        gray_s3_reg;
    logic [7:0]        r_out;
    logic [7:0]        g_out;
    logic [7:0]        b_out;
    logic [15:0]       pixel_reg;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg     <= BIAS_RESET;
            contrast_reg <= PCT_RESET;
            sat_reg      <= PCT_RESET;
            rgain_reg    <= PCT_RESET;
            ggain_reg    <= PCT_RESET;
            bgain_reg    <= PCT_RESET;
            kc_reg       <= pct_to_k128(PCT_RESET);
            ks_reg       <= pct_to_k128(PCT_RESET);
            kgr_reg      <= pct_to_k256(PCT_RESET);
            kgg_reg      <= pct_to_k256(PCT_RESET);
            kgb_reg      <= pct_to_k256(PCT_RESET);
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_BIAS:
                begin
                    bias_reg <= pwdata[7:0];
                end
                REG_CONTRAST:
                begin
                    contrast_reg <= pwdata[7:0];
                    kc_reg       <= pct_to_k128(pwdata[7:0]);
                end
                REG_SATURATION:
                begin
                    sat_reg <= pwdata[7:0];
                    ks_reg  <= pct_to_k128(pwdata[7:0]);
                end
                REG_RED_GAIN:
                begin
                    rgain_reg <= pwdata[7:0];
                    kgr_reg   <= pct_to_k256(pwdata[7:0]);
                end
                REG_GREEN_GAIN:
                begin
                    ggain_reg <= pwdata[7:0];
                    kgg_reg   <= pct_to_k256(pwdata[7:0]);
                end
                REG_BLUE_GAIN:
                begin
                    bgain_reg <= pwdata[7:0];
                    kgb_reg   <= pct_to_k256(pwdata[7:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_BIAS:       rd_byte = bias_reg;
            REG_CONTRAST:   rd_byte = contrast_reg;
            REG_SATURATION: rd_byte = sat_reg;
            REG_RED_GAIN:   rd_byte = rgain_reg;
            REG_GREEN_GAIN: rd_byte = ggain_reg;
            REG_BLUE_GAIN:  rd_byte = bgain_reg;
            default:        rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(DATA_W-8){1'b0}}, rd_byte};

    // stage loads, last stage first
    always_comb
    begin
        ctl.load[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            ctl.load[k] = !valid_reg[k] || ctl.load[k+1];
        end
    end

    assign in_ready = ctl.load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (ctl.load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // expand to 8 bits and luma
    always_comb
    begin
        r8        = {pixel_in[15:11], pixel_in[15:13]};
        g8        = {pixel_in[10:5], pixel_in[10:9]};
        b8        = {pixel_in[4:0], pixel_in[4:2]};
        luma_sum  = 15'(r8) * 15'(LUMA_R) + 15'(g8) * 15'(LUMA_G) + 15'(b8) * 15'(LUMA_B);
        gray_next = luma_sum[14:7];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            gray_s1_reg <= gray_next;
            last_reg[0] <= last_in;
        end
        if (ctl.load[1])
        begin
            gray_s2_reg <= gray_s1_reg;
        end
        if (ctl.load[2])
        begin
            gray_s3_reg <= gray_s2_reg;
        end
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (ctl.load[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
        if (ctl.load[NSTAGE-1])
        begin
            pixel_reg <= {r_out[7:3], g_out[7:2], b_out[7:3]};
        end
    end

    rcf_chan u_chan_r (
        .clk      (clk),
        .ctl      (ctl),
        .chan_in  (r8),
        .gray_s1  (gray_s1_reg),
        .gray_s3  (gray_s3_reg),
        .bias     ($signed(bias_reg)),
        .kc       (kc_reg),
        .ks       (ks_reg),
        .kg       (kgr_reg),
        .chan_out (r_out)
    );

    rcf_chan u_chan_g (
        .clk      (clk),
        .ctl      (ctl),
        .chan_in  (g8),
        .gray_s1  (gray_s1_reg),
        .gray_s3  (gray_s3_reg),
        .bias     ($signed(bias_reg)),
        .kc       (kc_reg),
        .ks       (ks_reg),
        .kg       (kgg_reg),
        .chan_out (g_out)
    );

    rcf_chan u_chan_b (
        .clk      (clk),
        .ctl      (ctl),
        .chan_in  (b8),
        .gray_s1  (gray_s1_reg),
        .gray_s3  (gray_s3_reg),
        .bias     ($signed(bias_reg)),
        .kc       (kc_reg),
        .ks       (ks_reg),
        .kg       (kgb_reg),
        .chan_out (b_out)
    );

    assign out_valid = valid_reg[NSTAGE-1];
    assign pixel_out = pixel_reg;
    assign last_out  = last_reg[NSTAGE-1];

endmodule

@@ sv/rcf_chan.sv @@
`timescale 1ns / 1ps
// one color channel of the filter pipeline: contrast, bias, saturation, gain
// depends on rcf_pkg; stage loads come from the top level

module rcf_chan (
    input  logic               clk,
    input  rcf_pkg::pipe_ctl_t ctl,
    input  logic [7:0]         chan_in,
    input  logic [7:0]         gray_s1,
    input  logic [7:0]         gray_s3,
    input  logic signed [7:0]  bias,
    input  logic [8:0]         kc,
    input  logic [8:0]         ks,
    input  logic [9:0]         kg,
    output logic [7:0]         chan_out
);
    import rcf_pkg::*;

    logic signed [9:0]  d1;
    logic signed [19:0] prod1_next;
    logic signed [16:0] prod1_reg;
    logic signed [16:0] adj1;
    logic signed [9:0]  q1;
    logic signed [10:0] v2;
    logic [7:0]         c2;
    logic signed [8:0]  diff_next;
    logic signed [8:0]  diff_reg;
    logic signed [18:0] prod2_next;
    logic signed [17:0] prod2_reg;
    logic signed [17:0] adj2;
    logic signed [10:0] q2;
    logic signed [11:0] v4;
    logic [7:0]         c3_next;
    logic [7:0]         c3_reg;
    logic [17:0]        prod3_next;
    logic [17:0]        prod3_reg;

    // contrast product
    always_comb
    begin
        d1         = $signed({2'b00, chan_in}) - 10'sd128;
        prod1_next = d1 * $signed({1'b0, kc});
    end

    // contrast divide toward zero, bias, clamp, distance from luma
    always_comb
    begin
        adj1 = prod1_reg + (prod1_reg[16] ? 17'sd127 : 17'sd0);
        q1   = adj1[16:7];
        v2   = $signed({q1[9], q1}) + 11'sd128 + $signed({{3{bias[7]}}, bias});
        if (v2[10])
        begin
            c2 = 8'd0;
        end
        else if (|v2[9:8])
        begin
            c2 = 8'hFF;
        end
        else
        begin
            c2 = v2[7:0];
        end
        diff_next = $signed({1'b0, c2}) - $signed({1'b0, gray_s1});
    end

    // saturation product
    assign prod2_next = diff_reg * $signed({1'b0, ks});

    // saturation divide toward zero, add luma, clamp
    always_comb
    begin
        adj2 = prod2_reg + (prod2_reg[17] ? 18'sd127 : 18'sd0);
        q2   = adj2[17:7];
        v4   = $signed({4'b0000, gray_s3}) + $signed({q2[10], q2});
        if (v4[11])
        begin
            c3_next = 8'd0;
        end
        else if (|v4[10:8])
        begin
            c3_next = 8'hFF;
        end
        else
        begin
            c3_next = v4[7:0];
        end
    end

    // gain product
    assign prod3_next = 18'(c3_reg) * 18'(kg);

    // gain divide by 256 and clamp
    assign chan_out = (|prod3_reg[17:16]) ? 8'hFF : prod3_reg[15:8];

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            prod1_reg <= prod1_next[16:0];
        end
        if (ctl.load[1])
        begin
            diff_reg <= diff_next;
        end
        if (ctl.load[2])
        begin
            prod2_reg <= prod2_next[17:0];
        end
        if (ctl.load[3])
        begin
            c3_reg <= c3_next;
        end
        if (ctl.load[4])
        begin
            prod3_reg <= prod3_next;
        end
    end

endmodule

@@ sv/rcf_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the rgb565 color filter, bound to the top level
// depends on rcf_pkg and rgb565_color_filter_exact_core

module rcf_port_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [15:0]                pixel_out,
    input logic                       last_out,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [rcf_pkg::ADDR_W-1:0] paddr,
    input logic [rcf_pkg::DATA_W-1:0] pwdata,
    input logic [rcf_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);
    import rcf_pkg::*;

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_out))
        else $error("output item changed while stalled");

    // a free output slot lets the input side move
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled with free output slot");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output item present after reset");

    // a register reads back what was just written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready) && psel && !pwrite
        && (paddr == $past(paddr)) && (paddr[4:2] < 3'(NUM_REGS))
        |-> prdata[7:0] == $past(pwdata[7:0]))
        else $error("register readback mismatch");

endmodule

bind rgb565_color_filter_exact_core rcf_port_checker u_rcf_checker (.*);
